// ===== design/bcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the banknote cartridge dispenser: sizes, reset values,
// register indexes, status codes and the microcode program.
// No dependencies.
package bcd_pkg;

	localparam int unsigned NUM_CART = 6;

	localparam int unsigned DENOM_W  = 16;
	localparam int unsigned COUNT_W  = 11;
	localparam int unsigned NOTES_W  = 6;
	localparam int unsigned AMOUNT_W = 18;
	localparam int unsigned BAL_W    = 32;
	localparam int unsigned IDX_W    = 3;
	localparam int unsigned CFG_W    = 16;

	typedef logic [DENOM_W-1:0]  denom_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [NOTES_W-1:0]  notes_t;
	typedef logic [AMOUNT_W-1:0] amount_t;
	typedef logic [BAL_W-1:0]    balance_t;
	typedef logic [IDX_W-1:0]    idx_t;

	localparam denom_t DENOM_RESET [NUM_CART] = '{
		16'd5000, 16'd2000, 16'd1000, 16'd500, 16'd200, 16'd100
	};
	localparam count_t COUNT_RESET    = 11'd1600;
	localparam count_t CAPACITY_RESET = 11'd2000;
	localparam notes_t MAX_RESET      = 6'd40;

	// Configuration register indexes.
	localparam idx_t CFG_CAPACITY  = 3'd6;
	localparam idx_t CFG_MAX_NOTES = 3'd7;
	localparam idx_t LAST_CART     = 3'd6;

	// Request kinds.
	localparam logic KIND_WITHDRAW = 1'b0;
	localparam logic KIND_DEPOSIT  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_COMPLETE = 2'd0,
		ST_LIMIT    = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_REFUSED  = 2'd3
	} status_t;

	// Microprogram step addresses.
	typedef enum logic [2:0] {
		PC_WAIT  = 3'd0,
		PC_CHECK = 3'd1,
		PC_WALK  = 3'd2,
		PC_FIN   = 3'd3,
		PC_SEND  = 3'd4
	} pc_t;

	typedef enum logic [2:0] {
		C_ALWAYS   = 3'd0,
		C_IN_XFER  = 3'd1,
		C_REFUSE   = 3'd2,
		C_WALK_END = 3'd3,
		C_OUT_XFER = 3'd4
	} cond_t;

	typedef enum logic [2:0] {
		A_LOAD   = 3'd0,
		A_CHECK  = 3'd1,
		A_WALK   = 3'd2,
		A_FINISH = 3'd3,
		A_SEND   = 3'd4
	} act_t;

	// One control word: handshake enables, datapath action, and a
	// conditional jump (taken target when the condition holds, else next).
	typedef struct packed {
		logic  in_rdy;
		logic  out_vld;
		act_t  act;
		cond_t cond;
		pc_t   jmp;
		pc_t   nxt;
	} uword_t;

	function automatic uword_t ucode_rom(input pc_t pc);
		uword_t w;
		unique case (pc)
			PC_WAIT:  w = '{1'b1, 1'b0, A_LOAD,   C_IN_XFER,  PC_CHECK, PC_WAIT};
			PC_CHECK: w = '{1'b0, 1'b0, A_CHECK,  C_REFUSE,   PC_SEND,  PC_WALK};
			PC_WALK:  w = '{1'b0, 1'b0, A_WALK,   C_WALK_END, PC_FIN,   PC_WALK};
			PC_FIN:   w = '{1'b0, 1'b0, A_FINISH, C_ALWAYS,   PC_SEND,  PC_SEND};
			PC_SEND:  w = '{1'b0, 1'b1, A_SEND,   C_OUT_XFER, PC_WAIT,  PC_SEND};
			default:  w = '{1'b0, 1'b0, A_SEND,   C_ALWAYS,   PC_WAIT,  PC_WAIT};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== design/bcd_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Request channel of the dispenser: valid/ready handshake with kind,
// amount and balance. Depends on bcd_pkg.
interface bcd_req_if;
	logic               valid;
	logic               ready;
	logic               kind;
	bcd_pkg::amount_t   amount;
	bcd_pkg::balance_t  balance;

	modport source (output valid, kind, amount, balance, input ready);
	modport sink   (input valid, kind, amount, balance, output ready);
endinterface
`default_nettype wire

// ===== design/bcd_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Result channel of the dispenser: valid/ready handshake with notes per
// cartridge, moved amount and status. Depends on bcd_pkg.
interface bcd_rsp_if;
	logic              valid;
	logic              ready;
	bcd_pkg::notes_t   notes_0;
	bcd_pkg::notes_t   notes_1;
	bcd_pkg::notes_t   notes_2;
	bcd_pkg::notes_t   notes_3;
	bcd_pkg::notes_t   notes_4;
	bcd_pkg::notes_t   notes_5;
	bcd_pkg::amount_t  moved_amount;
	logic [1:0]        status;

	modport source (output valid, notes_0, notes_1, notes_2, notes_3, notes_4, notes_5,
		moved_amount, status, input ready);
	modport sink   (input valid, notes_0, notes_1, notes_2, notes_3, notes_4, notes_5,
		moved_amount, status, output ready);
endinterface
`default_nettype wire

// ===== design/banknote_cartridge_dispenser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Banknote cartridge dispenser core: a five-step microprogram walks the six cartridges,
// moving one note or passing one cartridge per cycle; a refused withdrawal skips the walk.
// The result is offered after the walk and its finish step, or straight after the check for a
// refused withdrawal, and is held until its transfer; no new request is taken before that transfer.
// Ready for the next request returns in the cycle after the result transfer.
// Reset loads the default registers and 1600 notes per cartridge. Depends on bcd_pkg, bcd_req_if, bcd_rsp_if.
module banknote_cartridge_dispenser_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire bcd_pkg::idx_t                cfg_idx,
	input  wire logic [bcd_pkg::CFG_W-1:0]    cfg_data,
	bcd_req_if.sink                           req,
	bcd_rsp_if.source                         rsp
);
	import bcd_pkg::*;

	pc_t     pc_q, pc_next;
	uword_t  uw;
	logic    cond_hit;

	denom_t  denom_q [NUM_CART];
	count_t  cap_q;
	notes_t  max_q;
	count_t  counts_q [NUM_CART];

	notes_t  moved_q [NUM_CART];
	amount_t rem_q;
	amount_t amount_q;
	notes_t  total_q;
	idx_t    idx_q;
	logic    kind_q;
	logic    refuse_q;
	status_t status_q;

	logic    in_xfer, out_xfer;
	logic    walk_end, move_ok, cart_ok;
	denom_t  cur_denom;
	count_t  cur_count;
	logic    idx_valid;

	// Control store and sequencer.
	always_comb begin
		uw = ucode_rom(pc_q);
	end

	always_comb begin
		req.ready = uw.in_rdy;
		rsp.valid = uw.out_vld;
	end

	assign in_xfer  = req.valid & uw.in_rdy;
	assign out_xfer = rsp.ready & uw.out_vld;

	assign idx_valid = (idx_q < LAST_CART);
	always_comb begin
		cur_denom = '0;
		cur_count = '0;
		if (idx_valid) begin
			cur_denom = denom_q[idx_q];
			cur_count = counts_q[idx_q];
		end
	end

	assign walk_end = !idx_valid || (total_q >= max_q);
	assign cart_ok  = (kind_q == KIND_DEPOSIT) ? (cur_count < cap_q) : (cur_count != '0);
	// A zero denomination would match forever, so such a cartridge is passed over.
	assign move_ok  = (cur_denom != '0) && (rem_q >= {2'b00, cur_denom}) && cart_ok;

	always_comb begin
		unique case (uw.cond)
			C_ALWAYS:   cond_hit = 1'b1;
			C_IN_XFER:  cond_hit = in_xfer;
			C_REFUSE:   cond_hit = refuse_q;
			C_WALK_END: cond_hit = walk_end;
			C_OUT_XFER: cond_hit = out_xfer;
			default:    cond_hit = 1'b1;
		endcase
	end

	always_comb begin
		pc_next = cond_hit ? uw.jmp : uw.nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

	// Configuration registers and cartridge inventory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CART; i++) begin
				denom_q[i]  <= DENOM_RESET[i];
				counts_q[i] <= COUNT_RESET;
			end
			cap_q <= CAPACITY_RESET;
			max_q <= MAX_RESET;
		end else begin
			if (cfg_we) begin
				if (cfg_idx < LAST_CART) begin
					denom_q[cfg_idx] <= cfg_data;
				end else if (cfg_idx == CFG_CAPACITY) begin
					cap_q <= cfg_data[COUNT_W-1:0];
				end else if (cfg_idx == CFG_MAX_NOTES) begin
					max_q <= cfg_data[NOTES_W-1:0];
				end
			end
			if (uw.act == A_WALK && !walk_end && move_ok) begin
				if (kind_q == KIND_DEPOSIT) begin
					counts_q[idx_q] <= cur_count + 1'b1;
				end else begin
					counts_q[idx_q] <= cur_count - 1'b1;
				end
			end
		end
	end

	// Request datapath.
	always_ff @(posedge clk) begin
		unique case (uw.act)
			A_LOAD: begin
				if (in_xfer) begin
					kind_q   <= req.kind;
					amount_q <= req.amount;
					rem_q    <= req.amount;
					refuse_q <= (req.kind == KIND_WITHDRAW) &&
						({{(BAL_W-AMOUNT_W){1'b0}}, req.amount} > req.balance);
					total_q  <= '0;
					idx_q    <= '0;
					for (int i = 0; i < NUM_CART; i++) begin
						moved_q[i] <= '0;
					end
				end
			end
			A_CHECK: begin
				if (refuse_q) begin
					status_q <= ST_REFUSED;
				end
			end
			A_WALK: begin
				if (!walk_end) begin
					if (move_ok) begin
						rem_q          <= rem_q - {2'b00, cur_denom};
						moved_q[idx_q] <= moved_q[idx_q] + 1'b1;
						total_q        <= total_q + 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
			end
			A_FINISH: begin
				if (rem_q == '0) begin
					status_q <= ST_COMPLETE;
				end else if (total_q == max_q) begin
					status_q <= ST_LIMIT;
				end else begin
					status_q <= ST_EMPTY;
				end
			end
			A_SEND: begin
			end
			default: begin
			end
		endcase
	end

	// The result registers hold steady while the transfer waits.
	assign rsp.notes_0      = moved_q[0];
	assign rsp.notes_1      = moved_q[1];
	assign rsp.notes_2      = moved_q[2];
	assign rsp.notes_3      = moved_q[3];
	assign rsp.notes_4      = moved_q[4];
	assign rsp.notes_5      = moved_q[5];
	assign rsp.moved_amount = amount_q - rem_q;
	assign rsp.status       = status_q;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for banknote_cartridge_dispenser_core: sends withdraw and deposit requests,
// predicts every payout from a local copy of the cartridge inventory and checks each result.
// Depends on bcd_pkg, bcd_req_if, bcd_rsp_if and the core itself.
module tb;
	import bcd_pkg::*;

	localparam int      HALF_PERIOD     = 5;
	localparam int      STALL_LIMIT     = 2000;
	localparam int      SETTLE_CYCLES   = 80;
	localparam int      REPORT_LIMIT    = 10;
	localparam idx_t    CFG_DENOM_FIRST = 3'd0;
	localparam amount_t AMOUNT_MAX      = '1;

	typedef struct packed {
		notes_t [NUM_CART-1:0] notes;
		amount_t               moved;
		status_t               status;
	} payout_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	idx_t        cfg_idx;
	logic [15:0] cfg_data;

	bcd_req_if req ();
	bcd_rsp_if rsp ();

	// Local copy of the block's registers and inventory.
	denom_t  note_value [NUM_CART];
	count_t  stock [NUM_CART];
	count_t  capacity_limit;
	notes_t  note_limit;

	payout_t pending_payouts [$];
	int      failures;
	bit      steady;

	banknote_cartridge_dispenser_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp)
	);

	always #HALF_PERIOD clk = ~clk;

	// Greedy walk over the cartridges by index; updates the inventory copy.
	function automatic payout_t plan_payout(input logic kind, input amount_t amount,
		input balance_t balance);
		payout_t p;
		amount_t rest;
		notes_t  taken;
		logic    blocked;
		p = '0;
		p.status = ST_COMPLETE;
		if (kind == KIND_WITHDRAW && amount > balance) begin
			p.status = ST_REFUSED;
			return p;
		end
		rest = amount;
		taken = '0;
		for (int c = 0; c < NUM_CART; c++) begin
			blocked = (note_value[c] == '0);
			while (!blocked && taken < note_limit && rest >= note_value[c]) begin
				if (kind == KIND_WITHDRAW)
					blocked = (stock[c] == '0);
				else
					blocked = (stock[c] >= capacity_limit);
				if (!blocked) begin
					stock[c] = (kind == KIND_WITHDRAW) ? stock[c] - 1'b1 : stock[c] + 1'b1;
					rest = rest - note_value[c];
					p.notes[c] = p.notes[c] + 1'b1;
					taken = taken + 1'b1;
				end
			end
		end
		// The note limit wins over an empty or full cartridge.
		if (rest != '0)
			p.status = (taken == note_limit) ? ST_LIMIT : ST_EMPTY;
		p.moved = amount - rest;
		return p;
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("mismatch on %s: expected %0d, got %0d", field, want, got);
		end
	endfunction

	task automatic write_register(input idx_t idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CAPACITY:  capacity_limit = data[COUNT_W-1:0];
			CFG_MAX_NOTES: note_limit = data[NOTES_W-1:0];
			default:       note_value[idx] = data;
		endcase
		@(posedge clk);
	endtask

	task automatic write_denom(input int c, input denom_t value);
		write_register(CFG_DENOM_FIRST + idx_t'(c), value);
	endtask

	task automatic send_request(input logic kind, input amount_t amount, input balance_t balance);
		// Random gaps carry junk payload to show it is ignored while valid is low.
		while (!steady && $urandom_range(99) < 10) begin
			req.valid <= 1'b0;
			req.kind <= 1'($urandom);
			req.amount <= amount_t'($urandom);
			req.balance <= $urandom;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= kind;
		req.amount <= amount;
		req.balance <= balance;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		pending_payouts.insert(pending_payouts.size(), plan_payout(kind, amount, balance));
	endtask

	task automatic wait_for_payouts();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_payouts.size() != 0)
			@(posedge clk);
	endtask

	task automatic make_request(input int withdraw_pct, output logic kind,
		output amount_t amount, output balance_t balance);
		int              pick;
		longint unsigned sum;
		int unsigned     a;
		kind = ($urandom_range(99) < withdraw_pct) ? KIND_WITHDRAW : KIND_DEPOSIT;
		sum = 0;
		pick = $urandom_range(99);
		if (pick < 30 || pick >= 95) begin
			for (int c = 0; c < NUM_CART; c++)
				sum += note_value[c] * $urandom_range(6);
			if (pick >= 95)
				sum += $urandom_range(99, 1);
		end else if (pick < 50) begin
			sum = note_value[$urandom_range(NUM_CART - 1)] * $urandom_range(70, 1);
		end else if (pick < 70) begin
			sum = amount_t'($urandom);
		end else if (pick < 85) begin
			sum = $urandom_range(1000);
		end else if (pick < 90) begin
			sum = 0;
		end else begin
			sum = AMOUNT_MAX;
		end
		amount = (sum > AMOUNT_MAX) ? AMOUNT_MAX : amount_t'(sum);
		a = amount;
		pick = $urandom_range(99);
		if (pick < 40)
			balance = a + $urandom_range(100000);
		else if (pick < 55)
			balance = $urandom;
		else if (pick < 70)
			balance = a + $urandom_range(2) - 1;
		else if (pick < 85)
			balance = $urandom_range(a);
		else
			balance = (pick < 93) ? '1 : '0;
	endtask

	task automatic run_requests(input int count, input int withdraw_pct);
		logic     kind;
		amount_t  amount;
		balance_t balance;
		repeat (count) begin
			make_request(withdraw_pct, kind, amount, balance);
			send_request(kind, amount, balance);
		end
	endtask

	task automatic randomize_settings();
		int          pick;
		int          top;
		denom_t      value;
		logic [15:0] word;
		pick = $urandom_range(99);
		for (int c = 0; c < NUM_CART; c++) begin
			if (pick < 25)
				value = DENOM_RESET[c];
			else if (pick < 50)
				value = denom_t'($urandom_range(9, 1) * (NUM_CART - c) * 700);
			else if (pick < 75)
				value = denom_t'($urandom);
			else
				value = ($urandom_range(9) == 0) ? '0 : denom_t'($urandom_range(300, 1));
			write_denom(c, value);
		end
		top = 0;
		for (int c = 0; c < NUM_CART; c++)
			if (stock[c] > top)
				top = stock[c];
		word = 16'($urandom);
		if ($urandom_range(9) == 0)
			word[COUNT_W-1:0] = count_t'($urandom_range(2047));
		else
			word[COUNT_W-1:0] = (top + 150 > 2047) ? count_t'(2047) :
				count_t'(top + $urandom_range(150));
		write_register(CFG_CAPACITY, word);
		word = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 10)
			word[NOTES_W-1:0] = '0;
		else if (pick < 20)
			word[NOTES_W-1:0] = '1;
		else
			word[NOTES_W-1:0] = notes_t'($urandom_range(63, 1));
		write_register(CFG_MAX_NOTES, word);
	endtask

	task automatic test_default_settings();
		send_request(KIND_WITHDRAW, '0, '0);
		send_request(KIND_WITHDRAW, 18'd8800, 32'd8800);
		send_request(KIND_WITHDRAW, 18'd8801, 32'd8800);
		send_request(KIND_WITHDRAW, AMOUNT_MAX, '1);
		send_request(KIND_DEPOSIT, AMOUNT_MAX, '0);
		send_request(KIND_WITHDRAW, 18'd50, 32'd100);
		send_request(KIND_DEPOSIT, 18'd100, '0);
		send_request(KIND_WITHDRAW, 18'd1, '0);
		wait_for_payouts();
	endtask

	task automatic test_register_extremes();
		// Zero note limit, written with junk in the unused upper bits.
		write_register(CFG_MAX_NOTES, 16'hFFC0);
		send_request(KIND_WITHDRAW, 18'd5000, '1);
		send_request(KIND_DEPOSIT, '0, '0);
		wait_for_payouts();
		// Largest and smallest notes, with the middle cartridges switched off.
		write_register(CFG_MAX_NOTES, 16'd63);
		write_denom(0, 16'hFFFF);
		for (int c = 1; c < NUM_CART - 1; c++)
			write_denom(c, 16'd0);
		write_denom(NUM_CART - 1, 16'd1);
		send_request(KIND_WITHDRAW, 18'd65597, '1);
		send_request(KIND_WITHDRAW, AMOUNT_MAX, '1);
		send_request(KIND_DEPOSIT, AMOUNT_MAX, '0);
		wait_for_payouts();
		write_register(CFG_CAPACITY, 16'hF800);
		send_request(KIND_DEPOSIT, 18'd1000, '0);
		send_request(KIND_WITHDRAW, 18'd300, '1);
		wait_for_payouts();
		// Capacity equal to the current count of the smallest cartridge.
		write_register(CFG_CAPACITY, 16'(stock[NUM_CART-1]));
		send_request(KIND_DEPOSIT, 18'd3, '0);
		wait_for_payouts();
		write_register(CFG_CAPACITY, 16'd2047);
		send_request(KIND_DEPOSIT, AMOUNT_MAX, '0);
		wait_for_payouts();
		// Ascending denominations are still walked by cartridge index.
		for (int c = 0; c < NUM_CART; c++)
			write_denom(c, DENOM_RESET[NUM_CART-1-c]);
		send_request(KIND_WITHDRAW, 18'd12345, '1);
		send_request(KIND_DEPOSIT, 18'd7300, '0);
		wait_for_payouts();
		for (int c = 0; c < NUM_CART; c++)
			write_denom(c, DENOM_RESET[c]);
		write_register(CFG_CAPACITY, 16'(CAPACITY_RESET));
		write_register(CFG_MAX_NOTES, 16'(MAX_RESET));
	endtask

	task automatic test_drain_cartridges();
		write_register(CFG_MAX_NOTES, 16'd63);
		run_requests(250, 90);
		wait_for_payouts();
	endtask

	task automatic test_fill_cartridges();
		write_register(CFG_CAPACITY, 16'd300);
		run_requests(150, 10);
		wait_for_payouts();
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 6; phase++) begin
			randomize_settings();
			// One phase runs back to back with no idling on either side.
			steady = (phase == 3);
			run_requests(100, $urandom_range(70, 30));
			wait_for_payouts();
		end
		steady = 1'b0;
	endtask

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= steady || ($urandom_range(99) >= 10);
		end
	end

	always @(posedge clk) begin : payout_checker
		payout_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_payouts.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("result transfer with no request outstanding");
			end else begin
				want = pending_payouts.pop_front();
				check_field("notes_0", 32'(want.notes[0]), 32'(rsp.notes_0));
				check_field("notes_1", 32'(want.notes[1]), 32'(rsp.notes_1));
				check_field("notes_2", 32'(want.notes[2]), 32'(rsp.notes_2));
				check_field("notes_3", 32'(want.notes[3]), 32'(rsp.notes_3));
				check_field("notes_4", 32'(want.notes[4]), 32'(rsp.notes_4));
				check_field("notes_5", 32'(want.notes[5]), 32'(rsp.notes_5));
				check_field("moved_amount", 32'(want.moved), 32'(rsp.moved_amount));
				check_field("status", 32'(want.status), 32'(rsp.status));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("banknote_cartridge_dispenser_core verification failed");
		$finish;
	end

	initial begin
		for (int c = 0; c < NUM_CART; c++) begin
			note_value[c] = DENOM_RESET[c];
			stock[c] = COUNT_RESET;
		end
		capacity_limit = CAPACITY_RESET;
		note_limit = MAX_RESET;
		failures = 0;
		steady = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_data <= '0;
		req.valid <= 1'b0;
		req.kind <= KIND_WITHDRAW;
		req.amount <= '0;
		req.balance <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_settings();
		test_register_extremes();
		test_drain_cartridges();
		test_fill_cartridges();
		test_random_settings();
		wait_for_payouts();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && pending_payouts.size() == 0)
			$display("banknote_cartridge_dispenser_core verification clean");
		else
			$display("banknote_cartridge_dispenser_core verification failed");
		$finish;
	end

endmodule
